// ===== rtl/core/dssa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagnostic session / security access package
// Register indexes, response codes, session and sub-function codes and reset
// values used by the core.
// ----------------------------------------------------------------------------
package dssa_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCKOUT_MS   = 3'd0,
    CFG_MAX_ATTEMPTS = 3'd1,
    CFG_SEED_MASK    = 3'd2,
    CFG_KEY_XOR      = 3'd3,
    CFG_KEY_ADD      = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    NRC_NONE     = 3'd0,
    NRC_LEN      = 3'd1,
    NRC_SUB      = 3'd2,
    NRC_DELAY    = 3'd3,
    NRC_KEY      = 3'd4,
    NRC_ATTEMPTS = 3'd5
  } nrc_t;

  // Session types (low seven bits of the session control sub-function)
  localparam logic [6:0] SESS_SUB_DEFAULT  = 7'd1;
  localparam logic [6:0] SESS_SUB_PROG     = 7'd2;
  localparam logic [6:0] SESS_SUB_EXTENDED = 7'd3;

  localparam logic [1:0] SESS_DEFAULT  = 2'd1;
  localparam logic [1:0] SESS_EXTENDED = 2'd3;

  // Security access sub-functions
  localparam logic [7:0] SA_REQ_SEED = 8'd1;
  localparam logic [7:0] SA_SEND_KEY = 8'd2;

  // Minimum request lengths in bytes
  localparam logic [11:0] MIN_LEN     = 12'd2;
  localparam logic [11:0] MIN_KEY_LEN = 12'd6;

  localparam logic [15:0] LOCKOUT_MS_RST   = 16'd10000;
  localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd3;
  localparam logic [31:0] SEED_MASK_RST    = 32'hA5C3_E1F7;
  localparam logic [31:0] KEY_XOR_RST      = 32'h5A5A_5A5A;
  localparam logic [31:0] KEY_ADD_RST      = 32'h3618_BC91;

endpackage

// ===== rtl/core/dssa_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one diagnostic request word.
// ----------------------------------------------------------------------------
interface dssa_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  sub_function;
  logic [11:0] msg_length;
  logic [31:0] received_key;
  logic [31:0] now_ms;

  modport source (
    output valid, func, sub_function, msg_length, received_key, now_ms,
    input  ready
  );

  modport sink (
    input  valid, func, sub_function, msg_length, received_key, now_ms,
    output ready
  );
endinterface

// ===== rtl/core/dssa_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one diagnostic response word.
// ----------------------------------------------------------------------------
interface dssa_rsp_if;
  logic        valid;
  logic        ready;
  logic        negative;
  logic [2:0]  nrc;
  logic [7:0]  echo_sub;
  logic [31:0] seed_out;
  logic [1:0]  session_now;
  logic        unlocked;
  logic        reset_request;

  modport source (
    output valid, negative, nrc, echo_sub, seed_out, session_now, unlocked,
           reset_request,
    input  ready
  );

  modport sink (
    input  valid, negative, nrc, echo_sub, seed_out, session_now, unlocked,
           reset_request,
    output ready
  );
endinterface

// ===== rtl/core/diag_session_security_access_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagnostic session control and seed/key security access
// Session switching, seed generation, key check and bad-key lockout.
// ----------------------------------------------------------------------------
// Response: a response word is registered and valid the cycle after its request is accepted.
// Throughput: one request per cycle; the single response register frees up
// whenever the sink takes its word, so req.ready = !rsp.valid | rsp.ready.
// Reset (rst, synchronous): configuration and state registers return to their
// defaults, the session goes to default, access is locked, seed/retry/lockout clear.
// ----------------------------------------------------------------------------
module diag_session_security_access_unit
  import dssa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  dssa_req_if.sink              req,
  dssa_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [15:0] lockout_ms;
  logic [3:0]  max_attempts;
  logic [31:0] seed_mask;
  logic [31:0] key_xor;
  logic [31:0] key_add;

  // protocol state
  logic [1:0]  session_reg,   session_reg_next;
  logic        unlocked_reg,  unlocked_reg_next;
  logic [31:0] seed_reg,      seed_reg_next;
  logic [3:0]  retry_reg,     retry_reg_next;
  logic [31:0] lock_time_reg, lock_time_reg_next;

  // response register
  logic        rsp_valid;
  logic        rsp_negative;
  logic [2:0]  rsp_nrc;
  logic [7:0]  rsp_echo_sub;
  logic [31:0] rsp_seed_out;
  logic [1:0]  rsp_session_now;
  logic        rsp_unlocked;
  logic        rsp_reset_request;

  logic        req_fire;
  logic [6:0]  sess_sub;
  logic [31:0] elapsed;
  logic        lock_active;
  logic [31:0] expected_key;
  logic [3:0]  retry_inc;
  nrc_t        nrc;
  logic [7:0]  echo;
  logic [31:0] seed;
  logic        reset_req;

  assign req.ready = !rsp_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;

  assign sess_sub     = req.sub_function[6:0];
  assign elapsed      = req.now_ms - lock_time_reg;
  assign lock_active  = (lock_time_reg != 32'd0) && (elapsed < {16'd0, lockout_ms});
  assign expected_key = ((~seed_reg) ^ key_xor) + key_add;
  assign retry_inc    = retry_reg + 4'd1;

  always_comb begin
    session_reg_next   = session_reg;
    unlocked_reg_next  = unlocked_reg;
    seed_reg_next      = seed_reg;
    retry_reg_next     = retry_reg;
    lock_time_reg_next = lock_time_reg;
    nrc                = NRC_NONE;
    echo               = 8'd0;
    seed               = 32'd0;
    reset_req          = 1'b0;

    if (req.msg_length < MIN_LEN) begin
      nrc = NRC_LEN;
    end else if (!req.func) begin
      if (sess_sub == SESS_SUB_DEFAULT || sess_sub == SESS_SUB_EXTENDED) begin
        session_reg_next  = sess_sub[1:0];
        unlocked_reg_next = 1'b0;
        echo              = {1'b0, sess_sub};
      end else if (sess_sub == SESS_SUB_PROG) begin
        echo      = {1'b0, sess_sub};
        reset_req = 1'b1;
      end else begin
        nrc = NRC_SUB;
      end
    end else if (req.sub_function == SA_REQ_SEED) begin
      if (lock_active) begin
        nrc = NRC_DELAY;
      end else begin
        lock_time_reg_next = 32'd0;
        retry_reg_next     = 4'd0;
        seed_reg_next      = req.now_ms ^ seed_mask;
        seed               = req.now_ms ^ seed_mask;
        echo               = SA_REQ_SEED;
      end
    end else if (req.sub_function == SA_SEND_KEY) begin
      if (lock_active) begin
        nrc = NRC_DELAY;
      end else begin
        lock_time_reg_next = 32'd0;
        if (req.msg_length < MIN_KEY_LEN) begin
          nrc = NRC_LEN;
        end else if (req.received_key == expected_key) begin
          unlocked_reg_next = 1'b1;
          retry_reg_next    = 4'd0;
          echo              = SA_SEND_KEY;
        end else if (retry_inc >= max_attempts) begin
          // too many bad keys: open the lockout window
          lock_time_reg_next = req.now_ms;
          retry_reg_next     = 4'd0;
          nrc                = NRC_ATTEMPTS;
        end else begin
          retry_reg_next = retry_inc;
          nrc            = NRC_KEY;
        end
      end
    end else begin
      nrc = NRC_SUB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms   <= LOCKOUT_MS_RST;
      max_attempts <= MAX_ATTEMPTS_RST;
      seed_mask    <= SEED_MASK_RST;
      key_xor      <= KEY_XOR_RST;
      key_add      <= KEY_ADD_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOCKOUT_MS:   lockout_ms   <= cfg_wdata[15:0];
        CFG_MAX_ATTEMPTS: max_attempts <= cfg_wdata[3:0];
        CFG_SEED_MASK:    seed_mask    <= cfg_wdata;
        CFG_KEY_XOR:      key_xor      <= cfg_wdata;
        CFG_KEY_ADD:      key_add      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_reg   <= SESS_DEFAULT;
      unlocked_reg  <= 1'b0;
      seed_reg      <= 32'd0;
      retry_reg     <= 4'd0;
      lock_time_reg <= 32'd0;
    end else if (req_fire) begin
      session_reg   <= session_reg_next;
      unlocked_reg  <= unlocked_reg_next;
      seed_reg      <= seed_reg_next;
      retry_reg     <= retry_reg_next;
      lock_time_reg <= lock_time_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req.ready) begin
      rsp_valid <= req.valid;
    end
  end

  // hold the response word until the sink takes it
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp_negative      <= (nrc != NRC_NONE);
      rsp_nrc           <= nrc;
      rsp_echo_sub      <= echo;
      rsp_seed_out      <= seed;
      rsp_session_now   <= session_reg_next;
      rsp_unlocked      <= unlocked_reg_next;
      rsp_reset_request <= reset_req;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.negative      = rsp_negative;
  assign rsp.nrc           = rsp_nrc;
  assign rsp.echo_sub      = rsp_echo_sub;
  assign rsp.seed_out      = rsp_seed_out;
  assign rsp.session_now   = rsp_session_now;
  assign rsp.unlocked      = rsp_unlocked;
  assign rsp.reset_request = rsp_reset_request;

  a_lock_clears_retry: assert property (@(posedge clk) disable iff (rst)
    (lock_time_reg != 32'd0) |-> (retry_reg == 4'd0))
    else $error("retry count nonzero while a lockout time is stored");

  a_session_legal: assert property (@(posedge clk) disable iff (rst)
    (session_reg == SESS_DEFAULT) || (session_reg == SESS_EXTENDED))
    else $error("session register holds an unsupported session");

  a_nrc_matches_negative: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_negative == (rsp_nrc != NRC_NONE)))
    else $error("negative flag disagrees with response code");

  a_session_relocks: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !req.func && (req.msg_length >= MIN_LEN) &&
     ((sess_sub == SESS_SUB_DEFAULT) || (sess_sub == SESS_SUB_EXTENDED)))
    |=> !unlocked_reg)
    else $error("session change left security unlocked");

  a_reset_req_positive: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_reset_request) |-> !rsp_negative)
    else $error("reset request raised on a negative response");

endmodule
